// ===== design/vft_pkg.sv =====
// shared types, codes and defaults for the value frequency table
package vft_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;

	localparam int POS_W    = 6;
	localparam int COUNT_W  = 32;
	localparam int OUTVAL_W = 32;
	localparam int USED_W   = 7;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_NOT_USED = 2'd2
	} status_t;

	// control part of the item walking down the chain
	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
		logic       hit;
		logic       found;
	} tok_ctl_t;

	// entry data picked up by the item on its way
	typedef struct packed {
		logic [POS_W-1:0]    slot;
		logic [COUNT_W-1:0]  occ;
		logic [OUTVAL_W-1:0] ev;
	} tok_res_t;

	// one finished result
	typedef struct packed {
		logic                found;
		logic [POS_W-1:0]    slot;
		logic [COUNT_W-1:0]  occ;
		logic [OUTVAL_W-1:0] ev;
		logic [USED_W-1:0]   used;
		logic [1:0]          status;
	} result_t;

endpackage

// ===== design/vft_cell.sv =====
// one table entry: compare, count update, append and read, then pass the item on
module vft_cell #(
	parameter int INDEX      = 0,
	parameter int VALUE_BITS = vft_pkg::VALUE_BITS,
	parameter int TOTAL_W    = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vft_pkg::tok_ctl_t     ctl_in,
	input  logic [VALUE_BITS-1:0] value_in,
	input  logic [vft_pkg::POS_W-1:0] pos_in,
	input  logic [TOTAL_W-1:0]    total_in,
	input  vft_pkg::tok_res_t     res_in,
	output vft_pkg::tok_ctl_t     ctl_out,
	output logic [VALUE_BITS-1:0] value_out,
	output logic [vft_pkg::POS_W-1:0] pos_out,
	output logic [TOTAL_W-1:0]    total_out,
	output vft_pkg::tok_res_t     res_out
);

	localparam logic [TOTAL_W-1:0]        IDX      = TOTAL_W'(INDEX);
	localparam logic [vft_pkg::POS_W-1:0] IDX_SLOT = vft_pkg::POS_W'(INDEX);

	logic [VALUE_BITS-1:0]       value_q;
	logic [vft_pkg::COUNT_W-1:0] count_q;

	logic                        in_use;
	logic                        match;
	logic                        is_free;
	logic                        pos_match;
	logic [vft_pkg::COUNT_W-1:0] count_inc;
	logic [63:0]                 stored_ext;
	logic [63:0]                 new_ext;

	vft_pkg::tok_ctl_t ctl_d;
	vft_pkg::tok_res_t res_d;
	logic [TOTAL_W-1:0] total_d;
	logic               wr_value;
	logic               wr_count;
	logic [vft_pkg::COUNT_W-1:0] count_d;

	assign in_use     = IDX < total_in;
	assign match      = in_use && (value_q == value_in);
	assign is_free    = (IDX == total_in);
	assign pos_match  = in_use && (32'(pos_in) == 32'(INDEX));
	assign count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;
	assign stored_ext = 64'(value_q);
	assign new_ext    = 64'(value_in);

	always_comb begin
		ctl_d    = ctl_in;
		res_d    = res_in;
		total_d  = total_in;
		wr_value = 1'b0;
		wr_count = 1'b0;
		count_d  = count_inc;
		if (ctl_in.valid && !ctl_in.hit) begin
			unique case (ctl_in.mode)
				vft_pkg::MODE_ADD: begin
					if (match) begin
						wr_count    = 1'b1;
						ctl_d.hit   = 1'b1;
						ctl_d.found = 1'b1;
						res_d.slot  = IDX_SLOT;
						res_d.occ   = count_inc;
						res_d.ev    = stored_ext[vft_pkg::OUTVAL_W-1:0];
					end else if (is_free) begin
						// every entry in use was passed without a match
						wr_value   = 1'b1;
						wr_count   = 1'b1;
						count_d    = vft_pkg::COUNT_W'(1);
						ctl_d.hit  = 1'b1;
						res_d.slot = IDX_SLOT;
						res_d.occ  = vft_pkg::COUNT_W'(1);
						res_d.ev   = new_ext[vft_pkg::OUTVAL_W-1:0];
						total_d    = total_in + 1'b1;
					end
				end
				vft_pkg::MODE_QUERY: begin
					if (match) begin
						ctl_d.hit   = 1'b1;
						ctl_d.found = 1'b1;
						res_d.slot  = IDX_SLOT;
						res_d.occ   = count_q;
						res_d.ev    = stored_ext[vft_pkg::OUTVAL_W-1:0];
					end
				end
				vft_pkg::MODE_READ: begin
					if (pos_match) begin
						ctl_d.hit  = 1'b1;
						res_d.slot = IDX_SLOT;
						res_d.occ  = count_q;
						res_d.ev   = stored_ext[vft_pkg::OUTVAL_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_value) begin
			value_q <= value_in;
		end
		if (wr_count) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		value_out     <= value_in;
		pos_out       <= pos_in;
		total_out     <= total_d;
		res_out       <= res_d;
	end

endmodule

// ===== design/value_frequency_table_core.sv =====
// top level of the value frequency table: cell chain, entry count and result registers
//
// Keeps up to CAPACITY distinct values in order of first appearance, each with a
// saturating 32-bit occurrence count. Items arrive on in_valid/in_stall with
// mode, value and position; each produces one result on out_valid/out_stall.
// An item is taken when valid is high and stall is low at a rising clock edge.
//
// An accepted item walks down a row of CAPACITY cells, one cell per cycle. Each
// cell holds one entry, compares it with the item, and updates, appends or reads
// it as the mode asks. Only one item is inside the chain at a time, so the block
// takes no new item until the last one has left the chain and no result is parked.
//
// A finished result waits in the output register; if the receiver stalls when
// the next result comes out of the chain, that result parks in a skid register
// and in_stall stays high until it has moved on. Reset (arst_n low, asynchronous)
// empties the table and the output side; entry contents are not cleared, only
// entries below the entry count are ever looked at.
module value_frequency_table_core #(
	parameter int CAPACITY   = vft_pkg::CAPACITY,
	parameter int VALUE_BITS = vft_pkg::VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic signed [31:0] value,
	input  logic [5:0]  position,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [5:0]  slot,
	output logic [31:0] occurrences,
	output logic signed [31:0] entry_value,
	output logic [6:0]  used_entries,
	output logic [1:0]  status
);

	// entry count must also hold CAPACITY itself
	localparam int TOTAL_W = $clog2(CAPACITY + 1);

	// chain wiring, index k is the input of cell k, CAPACITY is the chain exit
	vft_pkg::tok_ctl_t         ctl_w   [0:CAPACITY];
	logic [VALUE_BITS-1:0]     value_w [0:CAPACITY];
	logic [vft_pkg::POS_W-1:0] pos_w   [0:CAPACITY];
	logic [TOTAL_W-1:0]        total_w [0:CAPACITY];
	vft_pkg::tok_res_t         res_w   [0:CAPACITY];

	logic               busy_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	logic               skid_valid_q;
	vft_pkg::result_t   out_q;
	vft_pkg::result_t   skid_q;

	logic              in_accept;
	logic              exit_valid;
	logic              out_free;
	logic signed [63:0] value_ext;
	vft_pkg::result_t  exit_res;

	// one item in flight; a parked result also holds off new items
	assign in_stall   = busy_q || skid_valid_q;
	assign in_accept  = in_valid && !in_stall;
	assign exit_valid = ctl_w[CAPACITY].valid;
	assign out_free   = !out_valid_q || !out_stall;

	// value is sign extended, then kept in its low VALUE_BITS bits
	assign value_ext = 64'(value);

	// item as it enters the first cell
	assign ctl_w[0].valid = in_accept;
	assign ctl_w[0].mode  = mode;
	assign ctl_w[0].hit   = 1'b0;
	assign ctl_w[0].found = 1'b0;
	assign value_w[0]     = value_ext[VALUE_BITS-1:0];
	assign pos_w[0]       = position;
	assign total_w[0]     = total_q;
	assign res_w[0]       = '0;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		vft_cell #(
			.INDEX      (k),
			.VALUE_BITS (VALUE_BITS),
			.TOTAL_W    (TOTAL_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_in    (ctl_w[k]),
			.value_in  (value_w[k]),
			.pos_in    (pos_w[k]),
			.total_in  (total_w[k]),
			.res_in    (res_w[k]),
			.ctl_out   (ctl_w[k+1]),
			.value_out (value_w[k+1]),
			.pos_out   (pos_w[k+1]),
			.total_out (total_w[k+1]),
			.res_out   (res_w[k+1])
		);
	end

	// final status from what the item met along the chain
	always_comb begin
		exit_res.found = ctl_w[CAPACITY].found;
		exit_res.slot  = res_w[CAPACITY].slot;
		exit_res.occ   = res_w[CAPACITY].occ;
		exit_res.ev    = res_w[CAPACITY].ev;
		exit_res.used  = vft_pkg::USED_W'(total_w[CAPACITY]);
		exit_res.status = vft_pkg::STATUS_OK;
		unique case (ctl_w[CAPACITY].mode)
			vft_pkg::MODE_ADD: begin
				// no match and no free entry: table full, value dropped
				if (!ctl_w[CAPACITY].hit) begin
					exit_res.status = vft_pkg::STATUS_FULL;
				end
			end
			vft_pkg::MODE_READ: begin
				if (!ctl_w[CAPACITY].hit) begin
					exit_res.status = vft_pkg::STATUS_NOT_USED;
				end
			end
			default: begin
			end
		endcase
	end

	// control: busy flag, entry count, output and skid valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (exit_valid) begin
				busy_q  <= 1'b0;
				total_q <= total_w[CAPACITY];
			end
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= exit_valid;
				end
			end else if (exit_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (exit_valid) begin
				out_q <= exit_res;
			end
		end else if (exit_valid) begin
			skid_q <= exit_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = out_q.found;
	assign slot         = out_q.slot;
	assign occurrences  = out_q.occ;
	assign entry_value  = out_q.ev;
	assign used_entries = out_q.used;
	assign status       = out_q.status;

endmodule
